// ===== rtl/core/gcd_pkg.sv =====
// Shared constants and small tables for the great-circle distance datapath.
// Used by gcd_sin and great_circle_distance_top; depends on nothing else.
package gcd_pkg;

    // Coordinate limits, 2^-22 degree units (signed) and magnitudes.
    localparam logic signed [29:0] LAT_MAX = 30'sd377487360;
    localparam logic signed [30:0] LON_MAX = 31'sd754974720;
    localparam logic [28:0] LAT_MAG = 29'd377487360;

    // Half-angle limits in 2^-23 degree units.
    localparam logic [29:0] QUARTER = 30'd754974720;
    localparam logic [30:0] HALF_TURN = 31'd1509949440;

    // Q30 constants.
    localparam logic [30:0] Q30_ONE = 31'd1073741824;
    localparam logic [30:0] HALFPI = 31'd1686629713;

    // Degrees (2^-23) to Q30 radians, scaled by 2^32.
    localparam logic [33:0] DEG_RAD = 34'd9595049034;

    localparam logic [12:0] EARTH_R = 13'd6371;
    localparam logic [22:0] DIST_MAX = 23'd5123863;

    // Configuration register indexes.
    localparam logic CFG_REF_LAT = 1'b0;
    localparam logic CFG_REF_LON = 1'b1;

    // Pipeline geometry.
    localparam int TAYLOR_N = 6;
    localparam int SIN_LAT = 3 * TAYLOR_N + 4;
    localparam int FRONT_LAT = 5;
    localparam int AREA_LAT = 4;
    localparam int SQRT_BITS = 31;
    localparam int ATAN_BITS = 31;
    localparam int ATAN_LAT = SIN_LAT + 2;
    localparam int PIPE_DEPTH = FRONT_LAT + SIN_LAT + AREA_LAT + SQRT_BITS
                                + ATAN_BITS * ATAN_LAT + 1;

    // Divisors of the nested Taylor series for the sine.
    function automatic logic [7:0] taylor_div(input logic [2:0] idx);
        logic [7:0] k;
        begin
            unique case (idx)
                3'd0: k = 8'd156;
                3'd1: k = 8'd110;
                3'd2: k = 8'd72;
                3'd3: k = 8'd42;
                3'd4: k = 8'd20;
                3'd5: k = 8'd6;
                default: k = 8'd1;
            endcase
            return k;
        end
    endfunction

    // floor(2^34 / divisor); the quotient estimate is low by at most one.
    function automatic logic [31:0] taylor_recip(input logic [2:0] idx);
        logic [31:0] m;
        begin
            unique case (idx)
                3'd0: m = 32'd110127366;
                3'd1: m = 32'd156180628;
                3'd2: m = 32'd238609294;
                3'd3: m = 32'd409044504;
                3'd4: m = 32'd858993459;
                3'd5: m = 32'd2863311530;
                default: m = 32'd0;
            endcase
            return m;
        end
    endfunction

    function automatic logic signed [29:0] sat_lat(input logic signed [29:0] v);
        logic signed [29:0] r;
        begin
            if (v > LAT_MAX) r = LAT_MAX;
            else if (v < -LAT_MAX) r = -LAT_MAX;
            else r = v;
            return r;
        end
    endfunction

    function automatic logic signed [30:0] sat_lon(input logic signed [30:0] v);
        logic signed [30:0] r;
        begin
            if (v > LON_MAX) r = LON_MAX;
            else if (v < -LON_MAX) r = -LON_MAX;
            else r = v;
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/gcd_sin.sv =====
// Pipelined Q30 sine over 0..pi/2: nested Taylor series, three stages per term.
// Depends on gcd_pkg; every register advances only while i_en is high.
module gcd_sin (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_x,
    output logic [30:0] o_sin
);
    localparam int NT = gcd_pkg::TAYLOR_N;

    logic [30:0] r_x;
    logic [31:0] r_x2 [0:3*NT-3];
    logic [30:0] r_xd [0:3*NT];
    logic [31:0] r_p  [0:NT-1];
    logic [31:0] r_pq [0:NT-1];
    logic [29:0] r_q0 [0:NT-1];
    logic [30:0] r_t  [0:NT-1];
    logic [30:0] r_r;
    logic [30:0] r_out;

    logic [61:0] n_sq;
    logic [30:0] n_tin [0:NT-1];
    logic [62:0] n_pt  [0:NT-1];
    logic [63:0] n_pm  [0:NT-1];
    logic [31:0] n_rm  [0:NT-1];
    logic [29:0] n_q   [0:NT-1];
    logic [30:0] n_tn  [0:NT-1];
    logic [61:0] n_fr;

    always_comb begin
        n_sq = 62'(r_x) * 62'(r_x);
        n_tin[0] = gcd_pkg::Q30_ONE;
        for (int j = 1; j < NT; j++) begin
            n_tin[j] = r_t[j-1];
        end
        for (int j = 0; j < NT; j++) begin
            n_pt[j] = 63'(r_x2[3*j]) * 63'(n_tin[j]);
            n_pm[j] = 64'(r_p[j]) * 64'(gcd_pkg::taylor_recip(3'(j)));
            // The reciprocal estimate is at most one low; one compare fixes it.
            n_rm[j] = r_pq[j] - 32'(r_q0[j]) * 32'(gcd_pkg::taylor_div(3'(j)));
            n_q[j] = r_q0[j] + {29'd0, (n_rm[j] >= 32'(gcd_pkg::taylor_div(3'(j))))};
            n_tn[j] = gcd_pkg::Q30_ONE - 31'(n_q[j]);
        end
        n_fr = 62'(r_xd[3*NT]) * 62'(r_t[NT-1]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= (i_x > gcd_pkg::HALFPI) ? gcd_pkg::HALFPI : i_x;
            r_x2[0] <= n_sq[61:30];
            r_xd[0] <= r_x;
            for (int s = 1; s <= 3*NT-3; s++) begin
                r_x2[s] <= r_x2[s-1];
            end
            for (int s = 1; s <= 3*NT; s++) begin
                r_xd[s] <= r_xd[s-1];
            end
            for (int j = 0; j < NT; j++) begin
                r_p[j] <= n_pt[j][61:30];
                r_pq[j] <= r_p[j];
                r_q0[j] <= n_pm[j][63:34];
                r_t[j] <= n_tn[j];
            end
            r_r <= n_fr[60:30];
            r_out <= (r_r > gcd_pkg::Q30_ONE) ? gcd_pkg::Q30_ONE : r_r;
        end
    end

    assign o_sin = r_out;

endmodule

// ===== rtl/core/great_circle_distance_top.sv =====
// Haversine great-circle distance from a query point to a configured reference.
// Throughput: one item per cycle while o_stall is low; every stage is a register,
// the longest chain being the 31 successive-approximation steps of atan2, each a
// 22-stage sine plus two stages.
// Reset (synchronous, active low) clears all valid bits and both reference registers.
// Depends on gcd_pkg and gcd_sin.
module great_circle_distance_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [29:0] i_query_latitude,
    input  logic signed [30:0] i_query_longitude,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [22:0]        o_distance_km,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [30:0]        i_cfg_data
);
    localparam int D  = gcd_pkg::PIPE_DEPTH;
    localparam int SL = gcd_pkg::SIN_LAT;
    localparam int NA = gcd_pkg::ATAN_BITS;
    localparam int NS = gcd_pkg::SQRT_BITS;

    // Pipeline control
    logic [D-1:0] r_vld;
    logic         r_vout;
    logic         adv;
    logic         out_load;

    // Bubbles ahead of the output register may close up while a result waits.
    assign out_load = !r_vout || !i_stall;
    assign adv = out_load || !r_vld[D-1];
    assign o_stall = !adv;
    assign o_valid = r_vout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_vout <= 1'b0;
        end else begin
            if (adv) begin
                r_vld <= {r_vld[D-2:0], i_valid};
            end
            if (out_load) begin
                r_vout <= r_vld[D-1];
            end
        end
    end

    // Reference point
    logic signed [29:0] r_ref_lat;
    logic signed [30:0] r_ref_lon;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_lat <= '0;
            r_ref_lon <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gcd_pkg::CFG_REF_LAT: r_ref_lat <= gcd_pkg::sat_lat(i_cfg_data[29:0]);
                gcd_pkg::CFG_REF_LON: r_ref_lon <= gcd_pkg::sat_lon(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Front end: clamp, differences, half-angle reduction, degree-to-radian.
    logic signed [29:0] r1_qlat;
    logic signed [30:0] r1_qlon;
    logic [30:0] r2_dlat;
    logic [31:0] r2_dlon;
    logic [28:0] r2_aqlat;
    logic [29:0] r_u   [0:3];
    logic [46:0] r_ph  [0:3];
    logic [46:0] r_pl  [0:3];
    logic [30:0] r_rad [0:3];

    logic [28:0] n_arlat;
    logic [30:0] n_adlat;
    logic [30:0] n_adlon;
    logic [30:0] n_clon;
    logic [29:0] n_u [0:3];
    logic [62:0] n_rsum [0:3];

    always_comb begin
        n_arlat = r_ref_lat[29] ? 29'(30'd0 - r_ref_lat) : r_ref_lat[28:0];
        n_adlat = r2_dlat[30] ? (31'd0 - r2_dlat) : r2_dlat;
        n_adlon = r2_dlon[31] ? 31'(32'd0 - r2_dlon) : r2_dlon[30:0];
        n_clon = (n_adlon > gcd_pkg::HALF_TURN) ? gcd_pkg::HALF_TURN : n_adlon;
        n_u[0] = (n_adlat > 31'(gcd_pkg::QUARTER)) ? gcd_pkg::QUARTER : n_adlat[29:0];
        // Longitude beyond a quarter turn folds back: sin(180 - h) = sin(h).
        n_u[1] = (n_clon > 31'(gcd_pkg::QUARTER)) ?
                 30'(gcd_pkg::HALF_TURN - n_clon) : n_clon[29:0];
        // A cosine of a latitude is the sine of its co-latitude.
        n_u[2] = {gcd_pkg::LAT_MAG - n_arlat, 1'b0};
        n_u[3] = {gcd_pkg::LAT_MAG - r2_aqlat, 1'b0};
        for (int l = 0; l < 4; l++) begin
            n_rsum[l] = (63'(r_ph[l]) << 17) + 63'(r_pl[l]) + (63'(1) << 31);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_qlat <= gcd_pkg::sat_lat(i_query_latitude);
            r1_qlon <= gcd_pkg::sat_lon(i_query_longitude);
            r2_dlat <= {r1_qlat[29], r1_qlat} - {r_ref_lat[29], r_ref_lat};
            r2_dlon <= {r1_qlon[30], r1_qlon} - {r_ref_lon[30], r_ref_lon};
            r2_aqlat <= r1_qlat[29] ? 29'(30'd0 - r1_qlat) : r1_qlat[28:0];
            for (int l = 0; l < 4; l++) begin
                r_u[l] <= n_u[l];
                r_ph[l] <= 47'(r_u[l]) * 47'(gcd_pkg::DEG_RAD[33:17]);
                r_pl[l] <= 47'(r_u[l]) * 47'(gcd_pkg::DEG_RAD[16:0]);
                r_rad[l] <= (n_rsum[l][62:32] > gcd_pkg::HALFPI) ?
                            gcd_pkg::HALFPI : n_rsum[l][62:32];
            end
        end
    end

    // Four sines: half-angle latitude, half-angle longitude, two cosines.
    logic [30:0] n_sin [0:3];

    for (genvar l = 0; l < 4; l++) begin : g_front_sin
        gcd_sin u_sin (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_x   (r_rad[l]),
            .o_sin (n_sin[l])
        );
    end

    // Haversine term a.
    logic [30:0] r_sl2;
    logic [30:0] r_so2;
    logic [30:0] r_c1a;
    logic [30:0] r_c2a;
    logic [30:0] r_m1;
    logic [30:0] r_sl2b;
    logic [30:0] r_c2b;
    logic [30:0] r_m2;
    logic [30:0] r_sl2c;
    logic [30:0] r_a;

    logic [61:0] n_slsq;
    logic [61:0] n_sosq;
    logic [61:0] n_m1;
    logic [61:0] n_m2;
    logic [31:0] n_asum;

    always_comb begin
        n_slsq = 62'(n_sin[0]) * 62'(n_sin[0]);
        n_sosq = 62'(n_sin[1]) * 62'(n_sin[1]);
        n_m1 = 62'(r_so2) * 62'(r_c1a);
        n_m2 = 62'(r_m1) * 62'(r_c2b);
        n_asum = 32'(r_sl2c) + 32'(r_m2);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sl2 <= n_slsq[60:30];
            r_so2 <= n_sosq[60:30];
            r_c1a <= n_sin[2];
            r_c2a <= n_sin[3];
            r_m1 <= n_m1[60:30];
            r_sl2b <= r_sl2;
            r_c2b <= r_c2a;
            r_m2 <= n_m2[60:30];
            r_sl2c <= r_sl2b;
            r_a <= (n_asum > 32'(gcd_pkg::Q30_ONE)) ? gcd_pkg::Q30_ONE : n_asum[30:0];
        end
    end

    // Two square roots, one result bit per stage. Lane 0 gives y, lane 1 gives x.
    logic [60:0] r_rem  [0:1][0:NS-1];
    logic [30:0] r_root [0:1][0:NS-1];

    logic [60:0] n_rin  [0:1][0:NS-1];
    logic [30:0] n_oin  [0:1][0:NS-1];
    logic [61:0] n_scand[0:1][0:NS-1];
    logic        n_sge  [0:1][0:NS-1];

    always_comb begin
        n_rin[0][0] = {r_a, 30'd0};
        n_rin[1][0] = {gcd_pkg::Q30_ONE - r_a, 30'd0};
        for (int m = 0; m < 2; m++) begin
            n_oin[m][0] = '0;
            for (int k = 1; k < NS; k++) begin
                n_rin[m][k] = r_rem[m][k-1];
                n_oin[m][k] = r_root[m][k-1];
            end
            for (int k = 0; k < NS; k++) begin
                n_scand[m][k] = (62'(n_oin[m][k]) << (NS - k))
                              + (62'(1) << (2 * (NS - 1 - k)));
                n_sge[m][k] = {1'b0, n_rin[m][k]} >= n_scand[m][k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int m = 0; m < 2; m++) begin
                for (int k = 0; k < NS; k++) begin
                    if (n_sge[m][k]) begin
                        r_rem[m][k] <= 61'({1'b0, n_rin[m][k]} - n_scand[m][k]);
                        r_root[m][k] <= n_oin[m][k] | (31'(1) << (NS - 1 - k));
                    end else begin
                        r_rem[m][k] <= n_rin[m][k];
                        r_root[m][k] <= n_oin[m][k];
                    end
                end
            end
        end
    end

    // atan2(y, x) by successive approximation: bit k of theta is kept when
    // cand <= pi/2 and sin(cand) * x <= cos(cand) * y.
    logic [30:0] r_dth [0:NA-1][0:SL-1];
    logic [30:0] r_dx  [0:NA-1][0:SL-1];
    logic [30:0] r_dy  [0:NA-1][0:SL-1];
    logic        r_dok [0:NA-1][0:SL-1];
    logic [61:0] r_px  [0:NA-1];
    logic [61:0] r_py  [0:NA-1];
    logic [30:0] r_pth [0:NA-1];
    logic [30:0] r_pxv [0:NA-2];
    logic [30:0] r_pyv [0:NA-2];
    logic        r_pok [0:NA-1];
    logic [30:0] r_th  [0:NA-1];
    logic [30:0] r_xo  [0:NA-2];
    logic [30:0] r_yo  [0:NA-2];

    logic [30:0] n_thin [0:NA-1];
    logic [30:0] n_xin  [0:NA-1];
    logic [30:0] n_yin  [0:NA-1];
    logic [30:0] n_cand [0:NA-1];
    logic        n_ok   [0:NA-1];
    logic [30:0] n_sbin [0:NA-1];
    logic [30:0] n_sa   [0:NA-1];
    logic [30:0] n_sb   [0:NA-1];
    logic [30:0] n_thn  [0:NA-1];

    always_comb begin
        n_thin[0] = '0;
        n_xin[0] = r_root[1][NS-1];
        n_yin[0] = r_root[0][NS-1];
        for (int k = 1; k < NA; k++) begin
            n_thin[k] = r_th[k-1];
            n_xin[k] = r_xo[k-1];
            n_yin[k] = r_yo[k-1];
        end
        for (int k = 0; k < NA; k++) begin
            n_cand[k] = n_thin[k] | (31'(1) << (NA - 1 - k));
            n_ok[k] = n_cand[k] <= gcd_pkg::HALFPI;
            n_sbin[k] = n_ok[k] ? (gcd_pkg::HALFPI - n_cand[k]) : '0;
            n_thn[k] = (r_pok[k] && (r_px[k] <= r_py[k])) ?
                       (r_pth[k] | (31'(1) << (NA - 1 - k))) : r_pth[k];
        end
    end

    for (genvar k = 0; k < NA; k++) begin : g_atan
        gcd_sin u_sin_a (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_x   (n_cand[k]),
            .o_sin (n_sa[k])
        );
        gcd_sin u_sin_b (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_x   (n_sbin[k]),
            .o_sin (n_sb[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < NA; k++) begin
                r_dth[k][0] <= n_thin[k];
                r_dx[k][0] <= n_xin[k];
                r_dy[k][0] <= n_yin[k];
                r_dok[k][0] <= n_ok[k];
                for (int s = 1; s < SL; s++) begin
                    r_dth[k][s] <= r_dth[k][s-1];
                    r_dx[k][s] <= r_dx[k][s-1];
                    r_dy[k][s] <= r_dy[k][s-1];
                    r_dok[k][s] <= r_dok[k][s-1];
                end
                r_px[k] <= 62'(n_sa[k]) * 62'(r_dx[k][SL-1]);
                r_py[k] <= 62'(n_sb[k]) * 62'(r_dy[k][SL-1]);
                r_pth[k] <= r_dth[k][SL-1];
                r_pok[k] <= r_dok[k][SL-1];
                r_th[k] <= n_thn[k];
            end
            for (int k = 0; k < NA - 1; k++) begin
                r_pxv[k] <= r_dx[k][SL-1];
                r_pyv[k] <= r_dy[k][SL-1];
                r_xo[k] <= r_pxv[k];
                r_yo[k] <= r_pyv[k];
            end
        end
    end

    // Scale by the earth radius, round and saturate.
    logic [43:0] r_dprod;
    logic [22:0] r_dist;
    logic [43:0] n_dsum;

    assign n_dsum = r_dprod + (44'(1) << 20);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dprod <= 44'(gcd_pkg::EARTH_R) * 44'(r_th[NA-1]);
        end
        if (out_load) begin
            r_dist <= (n_dsum[43:21] > gcd_pkg::DIST_MAX) ? gcd_pkg::DIST_MAX
                                                           : n_dsum[43:21];
        end
    end

    assign o_distance_km = r_dist;

    // Checks
    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vout && i_stall && r_vld[D-1]) |-> o_stall)
        else $error("item taken while the pipeline could not advance");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted item did not enter the pipeline");

    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vout |-> !o_stall)
        else $error("input stalled with an empty output register");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vout |-> (r_dist <= gcd_pkg::DIST_MAX))
        else $error("distance beyond the saturation limit");

endmodule
